[rtl/uartx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART transmit framer package
// Shared types, frame phase constants and command codes.
// ----------------------------------------------------------------------------
package uartx_pkg;

  localparam int DATA_BITS = 8;
  localparam int PHASE_W   = 4;
  localparam int BYTE_W    = 8;
  localparam int MODE_W    = 2;

  localparam logic [PHASE_W-1:0] PH_IDLE   = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PH_START  = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] PH_DATA0  = PHASE_W'(3);
  localparam logic [PHASE_W-1:0] PH_PARITY = PHASE_W'(3 + DATA_BITS);
  localparam logic [PHASE_W-1:0] PH_STOP   = PHASE_W'(4 + DATA_BITS);

  localparam logic [MODE_W-1:0] PAR_NONE = 2'd0;
  localparam logic [MODE_W-1:0] PAR_EVEN = 2'd1;
  localparam logic [MODE_W-1:0] PAR_ODD  = 2'd2;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [PHASE_W-1:0] bit_phase;
    logic [BYTE_W-1:0]  shift_data;
    logic               ones_parity;
    logic               frame_busy;
    logic               line_level;
  } frame_state_t;

  typedef struct packed {
    logic load_rejected;
    logic frame_done;
    logic busy_res;
    logic tx_line;
  } tx_result_t;

endpackage

[rtl/uart_tx_parity_framer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART transmit parity framer
// Steps a serial frame (start, data LSB first, parity or stop, stop) per tick.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands: tuser is the command (0 load byte, 1 bit tick),
//   tdata is the byte to send, used by a load only. A load while idle starts a
//   frame; a load while busy is dropped and flagged in its result.
//   Each tick transaction advances the frame by one bit time; a frame of
//   DATA_BITS + 4 ticks ends with frame_done on its last tick.
//   m_axis returns exactly one result per command, in order.
//   cfg writes parity_mode (0 none, 1 even, 2 odd); write it only while no
//   transaction is in flight. The mode is read on the parity tick itself.
// Timing:
//   One command per cycle sustained while m_axis is ready. A result appears
//   on m_axis in the cycle after its command is taken, from a single output
//   register. When m_axis stalls, s_axis_tready falls while that register is
//   full and the command stream holds; nothing is lost.
// Reset:
//   rst clears the frame state, sets the line idle high, parity to none and
//   empties the output register.
// ----------------------------------------------------------------------------
module uart_tx_parity_framer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] tx_byte
  input  logic       s_axis_tuser,   // [0] cmd
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] tx_line, [1] busy_res, [2] frame_done,
                                     // [3] load_rejected, [7:4] zero
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data        // parity_mode
);
  import uartx_pkg::*;

  frame_state_t      state;
  frame_state_t      state_next;
  tx_result_t        step_result;
  tx_result_t        out_result;
  logic [MODE_W-1:0] parity_mode;
  logic              space;
  logic              in_accept;
  cmd_t              cmd;

  assign cmd           = cmd_t'(s_axis_tuser);
  assign s_axis_tready = space & ~rst;
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = {4'b0000, out_result};

  always_ff @(posedge clk) begin
    if (rst) begin
      parity_mode <= PAR_NONE;
    end else if (cfg_valid) begin
      parity_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.bit_phase   <= '0;
      state.shift_data  <= '0;
      state.ones_parity <= 1'b0;
      state.frame_busy  <= 1'b0;
      state.line_level  <= 1'b1;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  uartx_step u_step (
    .state       (state),
    .parity_mode (parity_mode),
    .cmd         (cmd),
    .tx_byte     (s_axis_tdata),
    .state_next  (state_next),
    .result      (step_result)
  );

  uartx_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (in_accept),
    .load_data (step_result),
    .space     (space),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_result)
  );

`ifndef ASSERT_OFF
  // the last tick of a frame must leave the framer idle
  a_stop_ends_frame: assert property (@(posedge clk) disable iff (rst)
    in_accept && cmd == CMD_TICK && state.frame_busy && state.bit_phase == PH_PARITY
    |=> !state.frame_busy)
    else $error("frame still busy after stop tick");

  a_phase_in_frame: assert property (@(posedge clk) disable iff (rst)
    state.frame_busy |-> state.bit_phase <= PH_STOP)
    else $error("bit phase beyond frame");

  a_idle_line_high: assert property (@(posedge clk) disable iff (rst)
    !state.frame_busy |-> state.line_level)
    else $error("line low while idle");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> m_axis_tvalid)
    else $error("result missing after accepted transaction");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1])
    else $error("frame_done reported with busy set");
`endif

endmodule

[rtl/uartx_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART transmit framer step logic
// Next frame state and result flags for one load or tick transaction.
// ----------------------------------------------------------------------------
module uartx_step (
  input  uartx_pkg::frame_state_t       state,
  input  logic [uartx_pkg::MODE_W-1:0]  parity_mode,
  input  uartx_pkg::cmd_t               cmd,
  input  logic [uartx_pkg::BYTE_W-1:0]  tx_byte,
  output uartx_pkg::frame_state_t       state_next,
  output uartx_pkg::tx_result_t         result
);
  import uartx_pkg::*;

  logic [PHASE_W-1:0] ph;
  logic               data_bit;

  assign ph       = state.bit_phase + PHASE_W'(1);
  assign data_bit = state.shift_data[0];

  always_comb begin
    state_next = state;
    result     = '0;
    case (cmd)
      CMD_LOAD: begin
        if (state.frame_busy) begin
          result.load_rejected = 1'b1;
        end else begin
          state_next.frame_busy  = 1'b1;
          state_next.bit_phase   = '0;
          state_next.shift_data  = tx_byte;
          state_next.ones_parity = 1'b0;
        end
      end
      CMD_TICK: begin
        if (state.frame_busy) begin
          state_next.bit_phase = ph;
          if (ph == PH_IDLE) begin
            state_next.line_level = 1'b1;
          end else if (ph == PH_START) begin
            state_next.line_level = 1'b0;
          end else if (ph >= PH_DATA0 && ph < PH_PARITY) begin
            // shift out LSB first, fold it into the running parity
            state_next.line_level  = data_bit;
            state_next.ones_parity = state.ones_parity ^ data_bit;
            state_next.shift_data  = {1'b0, state.shift_data[BYTE_W-1:1]};
          end else if (ph == PH_PARITY) begin
            case (parity_mode)
              PAR_EVEN: state_next.line_level = state.ones_parity;
              PAR_ODD:  state_next.line_level = ~state.ones_parity;
              default:  state_next.line_level = 1'b1;
            endcase
          end else begin
            // final stop bit, also any phase past the frame
            state_next.line_level = 1'b1;
            state_next.frame_busy = 1'b0;
            state_next.bit_phase  = '0;
            result.frame_done     = 1'b1;
          end
        end
      end
      default: ;
    endcase
    result.tx_line  = state_next.line_level;
    result.busy_res = state_next.frame_busy;
  end

endmodule

[rtl/uartx_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART transmit framer output register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module uartx_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  uartx_pkg::tx_result_t load_data,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_ready,
  output uartx_pkg::tx_result_t out_data
);
  import uartx_pkg::*;

  logic       valid;
  tx_result_t data;

  assign space     = ~valid | out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

[verif/uart_tx_parity_framer_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART transmit parity framer testbench
// Drives load and tick commands with random gaps on both stream sides. Each
// accepted command is run through a behavioural frame model. Every returned
// result is checked field by field against the oldest predicted result.
// Parity mode is rewritten between phases, once the result stream is quiet.
// ----------------------------------------------------------------------------
module uart_tx_parity_framer_core_test;
  import uartx_pkg::*;

  localparam int                CYCLE_LIMIT   = 300000;
  localparam int                IDLE_PCT      = 22;
  localparam int                FRAME_TICKS   = DATA_BITS + 4;
  localparam int                PHASE_ITEMS   = 125;
  localparam int                SETTLE_CYCLES = 4;
  localparam logic [MODE_W-1:0] PAR_RSVD      = 2'd3;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_TICK,
    ROW_MODE
  } row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [7:0] value;
    int         reps;
    bit         pinned;
    tx_result_t res;
  } stim_row_t;

  // Pinned results, from the lowest bit up: tx_line, busy_res, frame_done,
  // load_rejected.
  stim_row_t plan [10] = '{
    '{ROW_TICK, 8'h00,            1,  1'b1, tx_result_t'(4'b0001)}, // tick while idle
    '{ROW_MODE, {6'd0, PAR_ODD},  1,  1'b0, tx_result_t'(4'b0000)},
    '{ROW_LOAD, 8'h80,            1,  1'b1, tx_result_t'(4'b0011)}, // frame starts
    '{ROW_LOAD, 8'h7F,            1,  1'b1, tx_result_t'(4'b1011)}, // load while busy
    '{ROW_TICK, 8'h00,            10, 1'b0, tx_result_t'(4'b0000)}, // up to last data bit
    '{ROW_MODE, {6'd0, PAR_RSVD}, 1,  1'b0, tx_result_t'(4'b0000)}, // change mid-frame
    '{ROW_TICK, 8'h00,            1,  1'b0, tx_result_t'(4'b0000)}, // parity tick
    '{ROW_TICK, 8'h00,            1,  1'b1, tx_result_t'(4'b0101)}, // stop, done
    '{ROW_MODE, {6'd0, PAR_EVEN}, 1,  1'b0, tx_result_t'(4'b0000)},
    '{ROW_LOAD, 8'hFF,            13, 1'b0, tx_result_t'(4'b0000)}  // load, then ticks
  };

  logic [MODE_W-1:0] mode_plan [8] = '{PAR_NONE, PAR_EVEN, PAR_ODD, PAR_RSVD,
                                       PAR_ODD, PAR_EVEN, PAR_NONE, PAR_EVEN};

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] tx_byte
  logic       s_axis_tuser;   // [0] cmd
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [0] tx_line, [1] busy_res, [2] frame_done,
                              // [3] load_rejected, [7:4] zero
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;       // parity_mode

  frame_state_t      line_model;
  logic [MODE_W-1:0] parity_model;
  tx_result_t        pending_results[$];
  bit                pin_next;
  tx_result_t        pin_res;
  bit                cmd_taken;
  bit                mode_taken;
  int                idle_pct;
  int                live_items;
  int                mismatches;
  int                cycle_count;

  uart_tx_parity_framer_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advance the frame by one command and return the line and flags after it.
  function automatic tx_result_t frame_step(inout frame_state_t st,
                                            input logic [MODE_W-1:0] mode,
                                            input cmd_t cmd,
                                            input logic [7:0] byte_in);
    tx_result_t r;
    r = '0;
    if (cmd == CMD_LOAD) begin
      if (st.frame_busy) begin
        r.load_rejected = 1'b1;
      end else begin
        st.frame_busy  = 1'b1;
        st.bit_phase   = '0;
        st.shift_data  = byte_in;
        st.ones_parity = 1'b0;
      end
    end else if (st.frame_busy) begin
      st.bit_phase = st.bit_phase + PHASE_W'(1);
      if (st.bit_phase == PH_IDLE) begin
        st.line_level = 1'b1;
      end else if (st.bit_phase == PH_START) begin
        st.line_level = 1'b0;
      end else if (st.bit_phase >= PH_DATA0 && st.bit_phase < PH_PARITY) begin
        st.line_level  = st.shift_data[0];
        st.ones_parity = st.ones_parity ^ st.shift_data[0];
        st.shift_data  = st.shift_data >> 1;
      end else if (st.bit_phase == PH_PARITY) begin
        case (mode)
          PAR_EVEN: st.line_level = st.ones_parity;
          PAR_ODD:  st.line_level = ~st.ones_parity;
          default:  st.line_level = 1'b1;
        endcase
      end else begin
        // final stop bit; anything past the frame closes it too
        st.line_level = 1'b1;
        st.frame_busy = 1'b0;
        st.bit_phase  = '0;
        r.frame_done  = 1'b1;
      end
    end
    r.tx_line  = st.line_level;
    r.busy_res = st.frame_busy;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s is %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Sample all handshakes at the rising edge; inputs only move on falling edges.
  always @(posedge clk) begin
    tx_result_t want;
    tx_result_t got;
    cmd_taken  = 1'b0;
    mode_taken = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        parity_model = cfg_data;
        mode_taken   = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = tx_result_t'(m_axis_tdata[3:0]);
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", int'(m_axis_tdata), 0);
        end else begin
          want = pending_results.pop_front();
          if (got.tx_line != want.tx_line)
            report_mismatch("tx_line", int'(got.tx_line), int'(want.tx_line));
          if (got.busy_res != want.busy_res)
            report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
          if (got.frame_done != want.frame_done)
            report_mismatch("frame_done", int'(got.frame_done), int'(want.frame_done));
          if (got.load_rejected != want.load_rejected)
            report_mismatch("load_rejected", int'(got.load_rejected),
                            int'(want.load_rejected));
          if (m_axis_tdata[7:4] != 4'd0)
            report_mismatch("tdata pad", int'(m_axis_tdata[7:4]), 0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if ((s_axis_tuser == CMD_TICK) == line_model.frame_busy)
          live_items++;
        want = frame_step(line_model, parity_model, cmd_t'(s_axis_tuser), s_axis_tdata);
        pending_results.push_back(pin_next ? pin_res : want);
        cmd_taken = 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic send_cmd(input cmd_t cmd, input logic [7:0] byte_in,
                          input bit pin, input tx_result_t res);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    pin_next = pin;
    pin_res  = res;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= byte_in;
    do @(negedge clk); while (!cmd_taken);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write only once the stream has gone quiet.
  task automatic write_parity(input logic [MODE_W-1:0] mode);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(negedge clk); while (!mode_taken);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] random_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly whole frames with random data; stray loads land mid-frame.
  task automatic send_frame();
    send_cmd(CMD_LOAD, random_byte(), 1'b0, '0);
    for (int t = 0; t < FRAME_TICKS; t++) begin
      if ($urandom_range(99) < 5)
        send_cmd(CMD_LOAD, random_byte(), 1'b0, '0);
      send_cmd(CMD_TICK, random_byte(), 1'b0, '0);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(5, 1);
    if ($urandom_range(1)) begin
      repeat (n) send_cmd(CMD_TICK, random_byte(), 1'b0, '0);
    end else begin
      send_cmd(CMD_LOAD, random_byte(), 1'b0, '0);
      repeat (n) send_cmd(CMD_TICK, random_byte(), 1'b0, '0);
    end
  endtask

  initial begin
    int target;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= CMD_LOAD;
    cfg_valid     <= 1'b0;
    cfg_data      <= PAR_NONE;
    line_model   = '0;
    line_model.line_level = 1'b1;
    parity_model = PAR_NONE;
    pin_next     = 1'b0;
    pin_res      = '0;
    idle_pct     = IDLE_PCT;
    live_items   = 0;
    mismatches   = 0;
    cycle_count  = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_MODE: write_parity(plan[i].value[MODE_W-1:0]);
        ROW_LOAD: begin
          send_cmd(CMD_LOAD, plan[i].value, plan[i].pinned, plan[i].res);
          repeat (plan[i].reps - 1) send_cmd(CMD_TICK, 8'h00, 1'b0, '0);
        end
        default: begin
          repeat (plan[i].reps) send_cmd(CMD_TICK, plan[i].value, plan[i].pinned, plan[i].res);
        end
      endcase
    end

    foreach (mode_plan[p]) begin
      write_parity(mode_plan[p]);
      // hold one phase with no gaps on either side
      idle_pct = (p == 3) ? 0 : IDLE_PCT;
      target = live_items + PHASE_ITEMS;
      while (live_items < target) begin
        if ($urandom_range(99) < 80)
          send_frame();
        else
          send_noise();
      end
    end

    idle_pct = IDLE_PCT;
    drain_results();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
rtl/uartx_pkg.sv
rtl/uartx_step.sv
rtl/uartx_out_reg.sv
rtl/uart_tx_parity_framer_core.sv
verif/uart_tx_parity_framer_core_test.sv
